@@ rtl/core/hid_keycode_to_azerty_char_assert.svh @@
// Assertion macros used by the top-level RTL module.
`ifndef HID_KEYCODE_TO_AZERTY_CHAR_ASSERT_SVH
`define HID_KEYCODE_TO_AZERTY_CHAR_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define HKAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define HKAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/hkac_pkg.sv @@
`default_nettype none
package hkac_pkg;

  // HID usage codes
  localparam logic [7:0] SC_NONE       = 8'h00;
  localparam logic [7:0] SC_A          = 8'h04;
  localparam logic [7:0] SC_Z          = 8'h1D;
  localparam logic [7:0] SC_1          = 8'h1E;
  localparam logic [7:0] SC_0          = 8'h27;
  localparam logic [7:0] SC_ENTER      = 8'h28;
  localparam logic [7:0] SC_ESCAPE     = 8'h29;
  localparam logic [7:0] SC_BACKSPACE  = 8'h2A;
  localparam logic [7:0] SC_TAB        = 8'h2B;
  localparam logic [7:0] SC_SPACE      = 8'h2C;
  localparam logic [7:0] SC_MINUS      = 8'h2D;
  localparam logic [7:0] SC_EQUAL      = 8'h2E;
  localparam logic [7:0] SC_LBRACKET   = 8'h2F;
  localparam logic [7:0] SC_RBRACKET   = 8'h30;
  localparam logic [7:0] SC_BACKSLASH  = 8'h31;
  localparam logic [7:0] SC_SEMICOLON  = 8'h33;
  localparam logic [7:0] SC_APOSTROPHE = 8'h34;
  localparam logic [7:0] SC_COMMA      = 8'h36;
  localparam logic [7:0] SC_DOT        = 8'h37;
  localparam logic [7:0] SC_SLASH      = 8'h38;
  localparam logic [7:0] SC_CAPSLOCK   = 8'h39;
  localparam logic [7:0] SC_DELETE     = 8'h4C;

  // modifier byte bit positions
  localparam int MOD_LSHIFT_BIT = 1;
  localparam int MOD_RSHIFT_BIT = 5;

  // extended character codes
  localparam logic [7:0] CH_SECTION = 8'h80;
  localparam logic [7:0] CH_MICRO   = 8'h81;
  localparam logic [7:0] CH_UMLAUT  = 8'h82;
  localparam logic [7:0] CH_POUND   = 8'h83;
  localparam logic [7:0] CH_DEGREE  = 8'h84;

  // item held in the input stage
  typedef struct packed {
    logic [7:0] key_code;
    logic       shift;
    logic       caps;
  } hkac_item_t;

endpackage
`default_nettype wire

@@ rtl/core/hkac_xlate.sv @@
`default_nettype none
module hkac_xlate (
  input  hkac_pkg::hkac_item_t item_i,
  output logic [7:0]           char_code_o,
  output logic                 clear_o
);

  logic [7:0] us_ch;
  logic [7:0] az_ch;
  logic [7:0] low_ch;

  // usage code to US character
  always_comb begin
    us_ch = 8'h00;
    if (item_i.key_code >= hkac_pkg::SC_A && item_i.key_code <= hkac_pkg::SC_Z) begin
      us_ch = item_i.key_code - hkac_pkg::SC_A + 8'h41;
    end else if (item_i.key_code >= hkac_pkg::SC_1 && item_i.key_code < hkac_pkg::SC_0) begin
      us_ch = item_i.key_code - hkac_pkg::SC_1 + 8'h31;
    end else begin
      case (item_i.key_code)
        hkac_pkg::SC_0:          us_ch = 8'h30;
        hkac_pkg::SC_SPACE:      us_ch = 8'h20;
        hkac_pkg::SC_ENTER:      us_ch = 8'h0A;
        hkac_pkg::SC_TAB:        us_ch = 8'h09;
        hkac_pkg::SC_DELETE:     us_ch = 8'h7F;
        hkac_pkg::SC_COMMA:      us_ch = 8'h3C;
        hkac_pkg::SC_DOT:        us_ch = 8'h3E;
        hkac_pkg::SC_SLASH:      us_ch = 8'h3F;
        hkac_pkg::SC_SEMICOLON:  us_ch = 8'h3A;
        hkac_pkg::SC_APOSTROPHE: us_ch = 8'h22;
        hkac_pkg::SC_BACKSLASH:  us_ch = 8'h7C;
        hkac_pkg::SC_LBRACKET:   us_ch = 8'h7B;
        hkac_pkg::SC_RBRACKET:   us_ch = 8'h7D;
        hkac_pkg::SC_EQUAL:      us_ch = 8'h2B;
        hkac_pkg::SC_MINUS:      us_ch = 8'h5F;
        hkac_pkg::SC_BACKSPACE:  us_ch = 8'h08;
        hkac_pkg::SC_ESCAPE:     us_ch = 8'h1B;
        default:                 us_ch = 8'h00;
      endcase
    end
  end

  // US to AZERTY key positions
  always_comb begin
    case (us_ch)
      8'h41:   az_ch = 8'h51;
      8'h5A:   az_ch = 8'h57;
      8'h51:   az_ch = 8'h41;
      8'h57:   az_ch = 8'h5A;
      8'h4D:   az_ch = 8'h3F;
      8'h3C:   az_ch = 8'h2E;
      8'h3E:   az_ch = 8'h2F;
      8'h3F:   az_ch = hkac_pkg::CH_SECTION;
      8'h3A:   az_ch = 8'h4D;
      8'h22:   az_ch = 8'h25;
      8'h7C:   az_ch = hkac_pkg::CH_MICRO;
      8'h7B:   az_ch = hkac_pkg::CH_UMLAUT;
      8'h7D:   az_ch = hkac_pkg::CH_POUND;
      8'h5F:   az_ch = hkac_pkg::CH_DEGREE;
      default: az_ch = us_ch;
    endcase
  end

  // unshifted form
  always_comb begin
    if (az_ch >= 8'h41 && az_ch <= 8'h5A) begin
      low_ch = az_ch + 8'h20;
    end else begin
      case (az_ch) inside
        8'h31:                 low_ch = 8'h26;
        8'h32, 8'h37:          low_ch = 8'h65;
        8'h33:                 low_ch = 8'h22;
        8'h34:                 low_ch = 8'h27;
        8'h35:                 low_ch = 8'h28;
        8'h36:                 low_ch = 8'h2D;
        8'h38:                 low_ch = 8'h5F;
        8'h39:                 low_ch = 8'h63;
        8'h30:                 low_ch = 8'h61;
        8'h3F:                 low_ch = 8'h2C;
        8'h2E:                 low_ch = 8'h3B;
        8'h2F:                 low_ch = 8'h3A;
        hkac_pkg::CH_SECTION:  low_ch = 8'h21;
        8'h25:                 low_ch = 8'h75;
        hkac_pkg::CH_MICRO:    low_ch = 8'h2A;
        hkac_pkg::CH_UMLAUT:   low_ch = 8'h5E;
        hkac_pkg::CH_POUND:    low_ch = 8'h24;
        hkac_pkg::CH_DEGREE:   low_ch = 8'h29;
        8'h2B:                 low_ch = 8'h3D;
        default:               low_ch = az_ch;
      endcase
    end
  end

  // lowered when caps and shift agree; a release gives zero
  assign clear_o     = (item_i.key_code == hkac_pkg::SC_NONE);
  assign char_code_o = clear_o ? 8'h00 : ((item_i.caps == item_i.shift) ? low_ch : az_ch);

endmodule
`default_nettype wire

@@ rtl/core/hid_keycode_to_azerty_char.sv @@
// Result path: an accepted item is held in the input register, then its translation is
// captured in the result register, which drives out_tvalid.
// Throughput: one item per cycle; in_tready drops only while both stages hold items
// and out_tready is low.
// Reset (rst_n low, synchronous): caps lock flag cleared, both stages emptied.
`default_nettype none
module hid_keycode_to_azerty_char (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // key_code [7:0], modifier_bits [15:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // char_code [7:0], caps_on [8], zero [15:9]
  output logic             out_tuser   // clear_display
);

  `include "hid_keycode_to_azerty_char_assert.svh"

  logic                 caps_r;
  logic                 caps_nxt;
  logic                 s1_valid_r;
  hkac_pkg::hkac_item_t s1_item_r;
  hkac_pkg::hkac_item_t s1_item_nxt;
  logic                 out_valid_r;
  logic [7:0]           out_char_r;
  logic                 out_clr_r;
  logic                 out_caps_r;
  logic [7:0]           x_char;
  logic                 x_clr;
  logic                 in_acc;
  logic                 s2_ready;
  logic                 s1_is_caps;

  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_is_caps = (in_tdata[7:0] == hkac_pkg::SC_CAPSLOCK);
  // flag seen by the result is the value after this report
  assign caps_nxt   = caps_r ^ (in_acc && s1_is_caps);

  always_comb begin
    s1_item_nxt.key_code = in_tdata[7:0];
    s1_item_nxt.shift    = in_tdata[8 + hkac_pkg::MOD_LSHIFT_BIT]
                         | in_tdata[8 + hkac_pkg::MOD_RSHIFT_BIT];
    s1_item_nxt.caps     = caps_nxt;
  end

  hkac_xlate u_xlate (
    .item_i      (s1_item_r),
    .char_code_o (x_char),
    .clear_o     (x_clr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      caps_r <= caps_nxt;
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= s1_item_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      out_char_r <= x_char;
      out_clr_r  <= x_clr;
      out_caps_r <= s1_item_r.caps;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_caps_r, out_char_r};
  assign out_tuser  = out_clr_r;

  `HKAC_ASSERT_IMPL(a_clear_no_char, clk, rst_n, out_valid_r && out_clr_r, out_char_r == 8'h00)
  `HKAC_ASSERT_NEXT(a_caps_hold, clk, rst_n, !(in_acc && s1_is_caps), $stable(caps_r))
  `HKAC_ASSERT_NEXT(a_caps_stage, clk, rst_n, in_acc, s1_item_r.caps == caps_r)

endmodule
`default_nettype wire

@@ test/tb_hid_keycode_to_azerty_char.sv @@
`default_nettype none
module tb_hid_keycode_to_azerty_char;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  // control and punctuation codes not in the package
  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [7:0] MOD_NONE   = 8'h00;
  localparam logic [7:0] MOD_LSHIFT = 8'h01 << hkac_pkg::MOD_LSHIFT_BIT;
  localparam logic [7:0] MOD_RSHIFT = 8'h01 << hkac_pkg::MOD_RSHIFT_BIT;

  typedef struct {
    logic [7:0] char_code;
    logic       clear_display;
    logic       caps_on;
  } key_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // key_code [7:0], modifier_bits [15:8]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // char_code [7:0], caps_on [8], zero [15:9]
  logic        out_tuser;  // clear_display

  key_result_t expected_chars[$];
  logic        model_caps;
  int          mismatch_count;
  int          cycle_count;
  bit          tx_no_idle;
  bit          rx_no_idle;

  hid_keycode_to_azerty_char i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] us_layout_char(input logic [7:0] key);
    if (key >= hkac_pkg::SC_A && key <= hkac_pkg::SC_Z) return key - hkac_pkg::SC_A + "A";
    if (key >= hkac_pkg::SC_1 && key < hkac_pkg::SC_0) return key - hkac_pkg::SC_1 + "1";
    case (key)
      hkac_pkg::SC_0:          return "0";
      hkac_pkg::SC_SPACE:      return CH_SPACE;
      hkac_pkg::SC_ENTER:      return CH_LF;
      hkac_pkg::SC_TAB:        return CH_TAB;
      hkac_pkg::SC_DELETE:     return CH_DEL;
      hkac_pkg::SC_COMMA:      return "<";
      hkac_pkg::SC_DOT:        return ">";
      hkac_pkg::SC_SLASH:      return "?";
      hkac_pkg::SC_SEMICOLON:  return ":";
      hkac_pkg::SC_APOSTROPHE: return CH_DQUOT;
      hkac_pkg::SC_BACKSLASH:  return "|";
      hkac_pkg::SC_LBRACKET:   return "{";
      hkac_pkg::SC_RBRACKET:   return "}";
      hkac_pkg::SC_EQUAL:      return "+";
      hkac_pkg::SC_MINUS:      return "_";
      hkac_pkg::SC_BACKSPACE:  return CH_BS;
      hkac_pkg::SC_ESCAPE:     return CH_ESC;
      default:                 return CH_NONE;
    endcase
  endfunction

  function automatic logic [7:0] azerty_remap(input logic [7:0] c);
    case (c)
      "A":      return "Q";
      "Z":      return "W";
      "Q":      return "A";
      "W":      return "Z";
      "M":      return "?";
      "<":      return ".";
      ">":      return "/";
      "?":      return hkac_pkg::CH_SECTION;
      ":":      return "M";
      CH_DQUOT: return "%";
      "|":      return hkac_pkg::CH_MICRO;
      "{":      return hkac_pkg::CH_UMLAUT;
      "}":      return hkac_pkg::CH_POUND;
      "_":      return hkac_pkg::CH_DEGREE;
      default:  return c;
    endcase
  endfunction

  function automatic logic [7:0] unshifted_form(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c + 8'h20;
    case (c)
      "1":                  return "&";
      "2":                  return "e";
      "3":                  return CH_DQUOT;
      "4":                  return CH_APOS;
      "5":                  return "(";
      "6":                  return "-";
      "7":                  return "e";
      "8":                  return "_";
      "9":                  return "c";
      "0":                  return "a";
      "?":                  return ",";
      ".":                  return ";";
      "/":                  return ":";
      hkac_pkg::CH_SECTION: return "!";
      "%":                  return "u";
      hkac_pkg::CH_MICRO:   return "*";
      hkac_pkg::CH_UMLAUT:  return "^";
      hkac_pkg::CH_POUND:   return "$";
      hkac_pkg::CH_DEGREE:  return ")";
      "+":                  return "=";
      default:              return c;
    endcase
  endfunction

  // advances the caps flag copy, so call once per accepted item, in order
  function automatic key_result_t translate_report(input logic [7:0] key, input logic [7:0] mods);
    key_result_t res;
    logic        shift;
    res.char_code = CH_NONE;
    res.clear_display = 1'b0;
    if (key == hkac_pkg::SC_NONE) begin
      res.clear_display = 1'b1;
    end else begin
      if (key == hkac_pkg::SC_CAPSLOCK) model_caps = ~model_caps;
      res.char_code = azerty_remap(us_layout_char(key));
      shift = mods[hkac_pkg::MOD_LSHIFT_BIT] | mods[hkac_pkg::MOD_RSHIFT_BIT];
      if (model_caps == shift) res.char_code = unshifted_form(res.char_code);
    end
    res.caps_on = model_caps;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch at cycle %0d: %s got 0x%02h expected 0x%02h",
             cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // returns at the edge where the item is taken
  task automatic send_report(input logic [7:0] key, input logic [7:0] mods);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {mods, key};
    @(negedge clk);
    while (in_tready !== 1'b1) @(negedge clk);
    @(posedge clk);
    expected_chars.push_back(translate_report(key, mods));
  endtask

  // result side: random stall per item, compare before the taking edge
  initial begin : char_checker
    int          stall;
    key_result_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (out_tvalid !== 1'b1) @(negedge clk);
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected item, char_code", out_tdata[7:0], CH_NONE);
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[7:0] !== want.char_code)
          report_mismatch("char_code", out_tdata[7:0], want.char_code);
        if (out_tdata[8] !== want.caps_on)
          report_mismatch("caps_on", {7'b0, out_tdata[8]}, {7'b0, want.caps_on});
        if (out_tuser !== want.clear_display)
          report_mismatch("clear_display", {7'b0, out_tuser}, {7'b0, want.clear_display});
        if (out_tdata[15:9] !== 7'b0)
          report_mismatch("tdata padding", {1'b0, out_tdata[15:9]}, 8'h00);
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic test_release_and_unknown_keys();
    send_report(hkac_pkg::SC_NONE, MOD_NONE);
    send_report(hkac_pkg::SC_NONE, 8'hFF);
    send_report(8'hFF, 8'hFF);
    send_report(8'hFF, MOD_NONE);
    send_report(8'h01, MOD_LSHIFT);
    send_report(8'h32, MOD_NONE);
    send_report(hkac_pkg::SC_ENTER, 8'hDD);   // all bits but the shifts
    send_report(hkac_pkg::SC_DELETE, MOD_RSHIFT);
  endtask

  task automatic test_extended_chars();
    send_report(hkac_pkg::SC_SLASH, MOD_LSHIFT);
    send_report(hkac_pkg::SC_SLASH, MOD_NONE);
    send_report(hkac_pkg::SC_BACKSLASH, MOD_RSHIFT);
    send_report(hkac_pkg::SC_BACKSLASH, MOD_NONE);
    send_report(hkac_pkg::SC_LBRACKET, MOD_LSHIFT | MOD_RSHIFT);
    send_report(hkac_pkg::SC_LBRACKET, MOD_NONE);
    send_report(hkac_pkg::SC_RBRACKET, MOD_LSHIFT);
    send_report(hkac_pkg::SC_MINUS, MOD_RSHIFT);
    send_report(hkac_pkg::SC_MINUS, MOD_NONE);
  endtask

  task automatic test_caps_lock_toggle();
    send_report(hkac_pkg::SC_CAPSLOCK, MOD_NONE);
    send_report(hkac_pkg::SC_A, MOD_NONE);
    send_report(hkac_pkg::SC_A, MOD_LSHIFT);
    send_report(hkac_pkg::SC_Z, MOD_RSHIFT);
    send_report(hkac_pkg::SC_0, MOD_NONE);
    send_report(hkac_pkg::SC_NONE, MOD_NONE);
    send_report(hkac_pkg::SC_CAPSLOCK, MOD_LSHIFT);
    send_report(hkac_pkg::SC_1, MOD_NONE);
  endtask

  // mostly mapped keys with random modifiers, some releases, caps and unknowns
  task automatic test_random_typing();
    int          pick;
    logic [7:0]  key;
    for (int n = 0; n < 900; n++) begin
      if (n % 100 == 0) begin
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) key = hkac_pkg::SC_NONE;
      else if (pick < 13) key = hkac_pkg::SC_CAPSLOCK;
      else if (pick < 18) key = 8'($urandom_range(8'h3A, 8'hFF));
      else begin
        key = 8'($urandom_range(hkac_pkg::SC_A, hkac_pkg::SC_SLASH));
        if (key == 8'h32 || key == 8'h35) key = hkac_pkg::SC_DELETE;
      end
      send_report(key, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_reports();
    for (int n = 0; n < 400; n++) begin
      if (n % 80 == 0) begin
        tx_no_idle = ($urandom_range(0, 2) == 0);
        rx_no_idle = ($urandom_range(0, 2) == 0);
      end
      send_report(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : main
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 16'h0000;
    model_caps = 1'b0;
    mismatch_count = 0;
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_release_and_unknown_keys();
    test_extended_chars();
    test_caps_lock_toggle();
    test_random_typing();
    test_random_reports();

    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/hkac_pkg.sv
rtl/core/hkac_xlate.sv
rtl/core/hid_keycode_to_azerty_char.sv
test/tb_hid_keycode_to_azerty_char.sv
